/* rtl/esup_pkg.sv */
// Shared types and constants for the emulated serial port block.
// Used by the divider, the register port and the top level; no dependencies.
package esup_pkg;

  localparam int TIMER_BITS_DEFAULT = 20;

  // Shared divider operand widths.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  // Register port geometry: three 32-bit registers at byte addresses 0, 4, 8.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_LINE_LENGTH   = 2'd0;
  localparam logic [1:0] REG_DIRECT_MODE   = 2'd1;
  localparam logic [1:0] REG_OVERRUN_TICKS = 2'd2;

  localparam logic [7:0]  LINE_LENGTH_RST   = 8'd227;
  localparam logic [19:0] OVERRUN_TICKS_RST = 20'd78125;

  // Item function codes.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_PERIOD = 2'd1;
  localparam logic [1:0] FUNC_TXDATA = 2'd2;
  localparam logic [1:0] FUNC_STATUS = 2'd3;

  localparam logic [7:0]  PREFIX_MARK  = 8'hA8;
  localparam logic [6:0]  PREFIX_UPPER = 7'h54;
  localparam logic [15:0] PERIOD_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  line_length;
    logic        direct_mode;
    logic [19:0] overrun_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_RXDIV,
    ST_TXDIV,
    ST_PERDIV,
    ST_ACT,
    ST_EMIT
  } state_t;

endpackage

/* rtl/emulated_serial_uart_port.sv */
// Top level of the emulated serial port: sequencer, port state and result beats.
// Depends on esup_pkg, esup_div and esup_apb.
//
// The block takes one item at a time and holds in_ready low until the last result
// beat of that item has been taken. All modulo and division work runs on one shared
// restoring divider that retires one bit per cycle. A line tick with a running
// period does two remainder operations; with a period of one it does one; a tick
// while the period is idle does none. A period write that changes the value divides
// once, or not at all in direct mode or when the value is unchanged. Transmit writes
// and status reads use no division. Each item then yields one result beat, or two
// when a nine-bit prefix byte precedes the data byte.
module emulated_serial_uart_port #(
  parameter int TIMER_BITS = esup_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [15:0]                  write_data,
  input  logic                         rx_valid,
  input  logic [7:0]                   rx_byte,
  input  logic                         tx_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  read_data,
  output logic                         tx_valid,
  output logic [7:0]                   tx_byte,
  output logic                         irq_transmit,
  output logic                         irq_receive,
  output logic                         rx_accepted,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esup_pkg::ADDR_W-1:0]  paddr,
  input  logic [esup_pkg::DATA_W-1:0]  pwdata,
  output logic [esup_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import esup_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  state_t   state, state_next;

  esup_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esup_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Port state.
  logic [15:0]           period_value;
  logic                  nine_bit_mode;
  logic [15:0]           tick_period;
  logic [31:0]           tick_count;
  logic [15:0]           hold_word;
  logic                  hold_full;
  logic [15:0]           shift_word;
  logic                  shift_busy;
  logic [9:0]            receive_word;
  logic                  receive_full;
  logic                  overrun_flag;
  logic [7:0]            prefix_byte;
  logic [TIMER_BITS-1:0] since_receive;

  // Latched tick item and slot decisions.
  logic       item_rx_valid;
  logic [7:0] item_rx_byte;
  logic       item_tx_ready;
  logic       rx_slot;
  logic       tx_slot;

  // Result beat registers.
  logic        has_pre;
  logic        phase;
  logic [7:0]  pre_byte;
  logic [15:0] fin_rd;
  logic        fin_txv;
  logic [7:0]  fin_txb;
  logic        fin_irq_t;
  logic        fin_irq_r;
  logic        fin_acc;

  logic        in_fire;
  logic        out_fire;
  logic        first_beat;
  logic [18:0] period_plus;
  logic [18:0] period_num;
  logic [15:0] div_line;
  logic        timer_full;
  logic        overrun_due;
  logic        busy_after;
  logic        tx_load;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = (state == ST_EMIT);
  assign out_fire   = out_valid && out_ready;
  assign first_beat = has_pre && !phase;

  // ((period & 0x7fff) + 1) * 10 by shift and add.
  assign period_plus = 19'(write_data[14:0]) + 19'd1;
  assign period_num  = (period_plus << 3) + (period_plus << 1);
  assign div_line    = (cfg.line_length == 8'd0) ? 16'd1 : 16'(cfg.line_length);

  assign timer_full  = (since_receive == {TIMER_BITS{1'b1}});
  assign overrun_due = 32'(since_receive) > 32'(cfg.overrun_ticks);
  // The shift register frees only in a send slot with the line ready.
  assign busy_after  = shift_busy && !(tx_slot && item_tx_ready);
  // A transmit write with data goes straight through to a free shifter.
  assign tx_load     = (func == FUNC_TXDATA) && (write_data[9:0] != 10'd0) && !shift_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = tick_count;
    div_req.divisor  = tick_period;
    case (state)
      ST_IDLE: begin
        div_req.dividend = 32'(period_num);
        div_req.divisor  = div_line;
        if (in_fire) begin
          case (func)
            FUNC_TICK: begin
              state_next = (tick_period != 16'd0) ? ST_TICK : ST_EMIT;
            end
            FUNC_PERIOD: begin
              if (write_data != period_value && !cfg.direct_mode) begin
                div_req.start = 1'b1;
                state_next    = ST_PERDIV;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_TICK: begin
        div_req.start = 1'b1;
        if (tick_period == 16'd1) begin
          state_next = ST_TXDIV;
        end else begin
          div_req.divisor = tick_period - 16'd1;
          state_next      = ST_RXDIV;
        end
      end
      ST_RXDIV: begin
        div_req.divisor = tick_period - 16'd1;
        if (div_rsp.done) begin
          div_req.start   = 1'b1;
          div_req.divisor = tick_period;
          state_next      = ST_TXDIV;
        end
      end
      ST_TXDIV: begin
        if (div_rsp.done) begin
          state_next = ST_ACT;
        end
      end
      ST_PERDIV: begin
        div_req.dividend = 32'(period_num);
        div_req.divisor  = div_line;
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_ACT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_fire && !first_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Divider operands come from the item beat; only the dividend is latched, so the
  // user must keep the line length static while a beat is in flight (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      period_value  <= '0;
      nine_bit_mode <= 1'b0;
      tick_period   <= '0;
      tick_count    <= '0;
      hold_word     <= '0;
      hold_full     <= 1'b0;
      shift_word    <= '0;
      shift_busy    <= 1'b0;
      receive_word  <= '0;
      receive_full  <= 1'b0;
      overrun_flag  <= 1'b0;
      prefix_byte   <= '0;
      since_receive <= '0;
      has_pre       <= 1'b0;
      phase         <= 1'b0;
      fin_txv       <= 1'b0;
      fin_irq_t     <= 1'b0;
      fin_irq_r     <= 1'b0;
      fin_acc       <= 1'b0;
      rx_slot       <= 1'b0;
      tx_slot       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            phase     <= 1'b0;
            fin_irq_r <= 1'b0;
            fin_acc   <= 1'b0;
            rx_slot   <= 1'b0;
            tx_slot   <= 1'b0;
            item_rx_valid <= rx_valid;
            item_rx_byte  <= rx_byte;
            item_tx_ready <= tx_ready;
            has_pre   <= tx_load && nine_bit_mode;
            pre_byte  <= PREFIX_MARK | {7'd0, write_data[8]};
            fin_txv   <= tx_load;
            fin_txb   <= tx_load ? write_data[7:0] : 8'd0;
            fin_irq_t <= tx_load;
            fin_rd    <= (func == FUNC_STATUS) ?
                         {overrun_flag, receive_full, !hold_full, !shift_busy,
                          2'b00, receive_word} : 16'd0;
            case (func)
              FUNC_TICK: begin
                if (!timer_full) begin
                  since_receive <= since_receive + 1'b1;
                end
                if (tick_period != 16'd0) begin
                  tick_count <= tick_count + 32'd1;
                end
              end
              FUNC_PERIOD: begin
                if (write_data != period_value) begin
                  period_value  <= write_data;
                  nine_bit_mode <= write_data[15];
                  tick_count    <= '0;
                  if (cfg.direct_mode) begin
                    tick_period <= 16'd1;
                  end
                end
              end
              FUNC_TXDATA: begin
                hold_word <= write_data;
                if (write_data[9:0] != 10'd0) begin
                  if (!shift_busy) begin
                    // Straight through the holding register into the shifter.
                    shift_word <= write_data;
                    shift_busy <= 1'b1;
                    hold_full  <= 1'b0;
                  end else begin
                    hold_full <= 1'b1;
                  end
                end
              end
              FUNC_STATUS: begin
                overrun_flag <= 1'b0;
                receive_full <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          if (tick_period == 16'd1) begin
            rx_slot <= 1'b1;
          end
        end
        ST_RXDIV: begin
          if (div_rsp.done) begin
            rx_slot <= (div_rsp.remainder == '0);
          end
        end
        ST_TXDIV: begin
          if (div_rsp.done) begin
            tx_slot <= (div_rsp.remainder == '0);
          end
        end
        ST_PERDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              tick_period <= 16'd1;
            end else if (div_rsp.quotient > 32'(PERIOD_MAX)) begin
              tick_period <= PERIOD_MAX;
            end else begin
              tick_period <= div_rsp.quotient[15:0];
            end
          end
        end
        ST_ACT: begin
          if (rx_slot && item_rx_valid) begin
            if (receive_full) begin
              if (overrun_due) begin
                overrun_flag <= 1'b1;
                fin_irq_r    <= 1'b1;
                fin_acc      <= 1'b1;
              end
            end else if (nine_bit_mode && prefix_byte == 8'd0) begin
              // Without a held prefix a byte is either the prefix or dropped.
              fin_acc <= 1'b1;
              if (item_rx_byte[7:1] == PREFIX_UPPER) begin
                prefix_byte <= item_rx_byte;
              end
            end else begin
              if (nine_bit_mode) begin
                receive_word <= {1'b1, prefix_byte[0], item_rx_byte};
                prefix_byte  <= '0;
              end else begin
                receive_word <= {2'b01, item_rx_byte};
              end
              receive_full  <= 1'b1;
              since_receive <= '0;
              fin_irq_r     <= 1'b1;
              fin_acc       <= 1'b1;
            end
          end
          if (tx_slot) begin
            if (hold_full && !busy_after) begin
              shift_word <= hold_word;
              shift_busy <= 1'b1;
              hold_full  <= 1'b0;
              has_pre    <= nine_bit_mode;
              pre_byte   <= PREFIX_MARK | {7'd0, hold_word[8]};
              fin_txv    <= 1'b1;
              fin_txb    <= hold_word[7:0];
              fin_irq_t  <= 1'b1;
            end else if (!busy_after) begin
              shift_busy <= 1'b0;
            end
          end
        end
        ST_EMIT: begin
          if (out_fire && first_beat) begin
            phase <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (first_beat) begin
      read_data    = '0;
      tx_valid     = 1'b1;
      tx_byte      = pre_byte;
      irq_transmit = 1'b0;
      irq_receive  = 1'b0;
      rx_accepted  = 1'b0;
      last         = 1'b0;
    end else begin
      read_data    = fin_rd;
      tx_valid     = fin_txv;
      tx_byte      = fin_txb;
      irq_transmit = fin_irq_t;
      irq_receive  = fin_irq_r;
      rx_accepted  = fin_acc;
      last         = 1'b1;
    end
  end

endmodule

/* rtl/esup_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, quotient and remainder.
// Depends on esup_pkg for operand widths and the request/response structs.
module esup_div (
  input  logic              clk,
  input  logic              rst,
  input  esup_pkg::div_req_t req,
  output esup_pkg::div_rsp_t rsp
);
  import esup_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The divisor must be held steady by the requester for the whole run.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, req.divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* rtl/esup_apb.sv */
// Configuration register file behind an APB-style port.
// Depends on esup_pkg for the register map and the cfg_t struct.
module esup_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esup_pkg::ADDR_W-1:0]  paddr,
  input  logic [esup_pkg::DATA_W-1:0]  pwdata,
  output logic [esup_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output esup_pkg::cfg_t               cfg
);
  import esup_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_length   <= LINE_LENGTH_RST;
      cfg.direct_mode   <= 1'b0;
      cfg.overrun_ticks <= OVERRUN_TICKS_RST;
    end else if (wr_en) begin
      case (reg_index)
        REG_LINE_LENGTH:   cfg.line_length   <= pwdata[7:0];
        REG_DIRECT_MODE:   cfg.direct_mode   <= pwdata[0];
        REG_OVERRUN_TICKS: cfg.overrun_ticks <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LINE_LENGTH:   prdata = DATA_W'(cfg.line_length);
      REG_DIRECT_MODE:   prdata = DATA_W'(cfg.direct_mode);
      REG_OVERRUN_TICKS: prdata = DATA_W'(cfg.overrun_ticks);
      default:           prdata = '0;
    endcase
  end

endmodule

/* test/emulated_serial_uart_port_test.sv */
// Self-checking bench for the emulated serial port: line ticks, period and transmit
// writes and status reads go in, and every result beat is checked against a predictor.
// Depends on esup_pkg and the emulated_serial_uart_port top level.
module emulated_serial_uart_port_test;
  import esup_pkg::*;

  localparam int AGE_BITS = TIMER_BITS_DEFAULT;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        tx_ready;
  } port_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_transmit;
    logic        irq_receive;
    logic        rx_accepted;
    logic        last;
  } uart_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  port_item_t live_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] read_data;
  logic tx_valid;
  logic [7:0] tx_byte;
  logic irq_transmit;
  logic irq_receive;
  logic rx_accepted;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  emulated_serial_uart_port u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(live_item.func), .write_data(live_item.write_data),
    .rx_valid(live_item.rx_valid), .rx_byte(live_item.rx_byte),
    .tx_ready(live_item.tx_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .tx_valid(tx_valid), .tx_byte(tx_byte),
    .irq_transmit(irq_transmit), .irq_receive(irq_receive),
    .rx_accepted(rx_accepted), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  port_item_t item_backlog[$];
  uart_beat_t owed_beats[$];
  uart_beat_t owed_head;
  int mismatch_count = 0;
  logic idle_on = 1'b1;
  int send_gap = 0;
  int take_gap = 0;
  logic [15:0] last_period_pick = '0;

  // Configuration as the block should hold it.
  logic [7:0]  cfg_line_length = LINE_LENGTH_RST;
  logic        cfg_direct_mode = 1'b0;
  logic [19:0] cfg_overrun_ticks = OVERRUN_TICKS_RST;

  // Port state as the block should hold it.
  logic [15:0] period_value = '0;
  logic        nine_bit = 1'b0;
  logic [15:0] tick_period = '0;
  logic [31:0] tick_count = '0;
  logic [15:0] hold_word = '0;
  logic        hold_full = 1'b0;
  logic [15:0] shift_word = '0;
  logic        shift_busy = 1'b0;
  logic [9:0]  receive_word = '0;
  logic        receive_full = 1'b0;
  logic        overrun = 1'b0;
  logic [7:0]  prefix_held = '0;
  logic [AGE_BITS-1:0] rx_age = '0;
  logic [7:0]  line_bytes[$];
  logic        tx_irq;

  function automatic void load_shift();
    shift_busy = 1'b1;
    shift_word = hold_word;
    if (nine_bit)
      line_bytes.push_back(PREFIX_MARK | {7'd0, shift_word[8]});
    line_bytes.push_back(shift_word[7:0]);
    hold_full = 1'b0;
    tx_irq = 1'b1;
  endfunction

  // Works out the result beats of one accepted item and queues them.
  function automatic void uart_predict(input port_item_t it);
    logic rx_irq;
    logic took;
    logic [15:0] status;
    logic [31:0] divisor;
    logic [31:0] per;
    logic rx_slot;
    uart_beat_t b;
    int n;
    line_bytes.delete();
    tx_irq = 1'b0;
    rx_irq = 1'b0;
    took = 1'b0;
    status = '0;
    case (it.func)
      FUNC_TICK: begin
        if (rx_age != '1)
          rx_age = rx_age + 1'b1;
        if (tick_period != 0) begin
          tick_count = tick_count + 1;
          if (tick_period == 1)
            rx_slot = 1'b1;
          else
            rx_slot = (tick_count % (32'(tick_period) - 32'd1)) == 0;
          if (rx_slot && it.rx_valid) begin
            if (receive_full) begin
              if (32'(rx_age) > 32'(cfg_overrun_ticks)) begin
                overrun = 1'b1;
                rx_irq = 1'b1;
                took = 1'b1;
              end
            end else if (nine_bit && prefix_held == 0) begin
              // Without a prefix the byte is dropped, unless it is a prefix itself.
              took = 1'b1;
              if (it.rx_byte[7:1] == PREFIX_UPPER)
                prefix_held = it.rx_byte;
            end else begin
              if (nine_bit) begin
                receive_word = {1'b1, prefix_held[0], it.rx_byte};
                prefix_held = '0;
              end else begin
                receive_word = {2'b01, it.rx_byte};
              end
              receive_full = 1'b1;
              rx_age = '0;
              rx_irq = 1'b1;
              took = 1'b1;
            end
          end
          if ((tick_count % 32'(tick_period)) == 0) begin
            if (shift_busy && it.tx_ready)
              shift_busy = 1'b0;
            if (hold_full && !shift_busy)
              load_shift();
          end
        end
      end
      FUNC_PERIOD: begin
        if (it.write_data != period_value) begin
          period_value = it.write_data;
          nine_bit = it.write_data[15];
          divisor = (cfg_line_length == 0) ? 32'd1 : 32'(cfg_line_length);
          per = ((32'(it.write_data[14:0]) + 32'd1) * 32'd10) / divisor;
          if (per == 0)
            per = 1;
          if (per > 32'(PERIOD_MAX))
            per = 32'(PERIOD_MAX);
          if (cfg_direct_mode)
            per = 1;
          tick_period = per[15:0];
          tick_count = '0;
        end
      end
      FUNC_TXDATA: begin
        hold_word = it.write_data;
        if (it.write_data[9:0] != 0) begin
          hold_full = 1'b1;
          if (!shift_busy)
            load_shift();
        end
      end
      default: begin
        status = {overrun, receive_full, !hold_full, !shift_busy, 2'b00, receive_word};
        overrun = 1'b0;
        receive_full = 1'b0;
      end
    endcase
    n = (line_bytes.size() > 0) ? line_bytes.size() : 1;
    for (int k = 0; k < n; k++) begin
      b = '0;
      if (k < line_bytes.size()) begin
        b.tx_valid = 1'b1;
        b.tx_byte = line_bytes[k];
      end
      if (k == n - 1) begin
        b.read_data = status;
        b.irq_transmit = tx_irq;
        b.irq_receive = rx_irq;
        b.rx_accepted = took;
        b.last = 1'b1;
      end
      owed_beats.push_back(b);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  // Input side: offers queued items, with random pauses between beats.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        uart_predict(live_item);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          live_item <= item_backlog.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 4) == 0)
            send_gap <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each beat taken and stalls the block in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_beats.size() == 0) begin
          flag_mismatch("beat with nothing owed", 32'(read_data), 0);
        end else begin
          owed_head = owed_beats.pop_front();
          if (read_data !== owed_head.read_data)
            flag_mismatch("read_data", 32'(read_data), 32'(owed_head.read_data));
          if (tx_valid !== owed_head.tx_valid)
            flag_mismatch("tx_valid", 32'(tx_valid), 32'(owed_head.tx_valid));
          if (tx_byte !== owed_head.tx_byte)
            flag_mismatch("tx_byte", 32'(tx_byte), 32'(owed_head.tx_byte));
          if (irq_transmit !== owed_head.irq_transmit)
            flag_mismatch("irq_transmit", 32'(irq_transmit), 32'(owed_head.irq_transmit));
          if (irq_receive !== owed_head.irq_receive)
            flag_mismatch("irq_receive", 32'(irq_receive), 32'(owed_head.irq_receive));
          if (rx_accepted !== owed_head.rx_accepted)
            flag_mismatch("rx_accepted", 32'(rx_accepted), 32'(owed_head.rx_accepted));
          if (last !== owed_head.last)
            flag_mismatch("last", 32'(last), 32'(owed_head.last));
        end
      end
      if (take_gap != 0) begin
        out_ready <= 1'b0;
        take_gap <= take_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        take_gap <= $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LINE_LENGTH:   cfg_line_length = value[7:0];
      REG_DIRECT_MODE:   cfg_direct_mode = value[0];
      REG_OVERRUN_TICKS: cfg_overrun_ticks = value[19:0];
      default: ;
    endcase
  endtask

  // Sampled on the falling edge so that it never races the beat handlers.
  task automatic wait_drained();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || owed_beats.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic void enqueue(input logic [1:0] f, input logic [15:0] wd,
                                  input logic rxv, input logic [7:0] rxb,
                                  input logic txr);
    port_item_t it;
    it.func = f;
    it.write_data = wd;
    it.rx_valid = rxv;
    it.rx_byte = rxb;
    it.tx_ready = txr;
    item_backlog.push_back(it);
  endfunction

  // Mostly a period that makes slots come every few ticks under the current line
  // length; now and then a wild value or a repeat of the previous one.
  function automatic logic [15:0] period_choice();
    int unsigned lines;
    int unsigned span;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: v = last_period_pick;
      default: begin
        lines = (cfg_line_length == 0) ? 1 : cfg_line_length;
        span = ($urandom_range(1, 6) * lines + 9) / 10;
        v = {1'($urandom), 15'(span - 1)};
      end
    endcase
    last_period_pick = v;
    return v;
  endfunction

  function automatic port_item_t random_item();
    port_item_t it;
    int pick;
    it.write_data = 16'($urandom);
    it.rx_valid = ($urandom_range(0, 3) != 0);
    it.rx_byte = ($urandom_range(0, 2) == 0) ? {PREFIX_UPPER, 1'($urandom)} : 8'($urandom);
    it.tx_ready = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      it.func = FUNC_TICK;
    end else if (pick < 64) begin
      it.func = FUNC_PERIOD;
      it.write_data = period_choice();
    end else if (pick < 82) begin
      it.func = FUNC_TXDATA;
      if ($urandom_range(0, 7) == 0)
        it.write_data[9:0] = '0;
    end else begin
      it.func = FUNC_STATUS;
    end
    return it;
  endfunction

  initial begin
    int unsigned ll;
    int unsigned dm;
    int unsigned ot;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset configuration.
    enqueue(FUNC_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h33, 1'b1);   // ticks still idle
    enqueue(FUNC_TXDATA, 16'hFC00, 1'b0, 8'h00, 1'b0);   // no data bits set
    enqueue(FUNC_TXDATA, 16'h01FF, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TXDATA, 16'h00AB, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TXDATA, 16'h00CD, 1'b0, 8'h00, 1'b0);   // overwrites the holding word
    enqueue(FUNC_PERIOD, 16'h0000, 1'b0, 8'h00, 1'b0);   // same as held value
    enqueue(FUNC_PERIOD, 16'h8000, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h55, 1'b1);   // no prefix yet, so dropped
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'hA9, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h00, 1'b1);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'hFF, 1'b1);   // left with the host
    enqueue(FUNC_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'hA8, 1'b1);
    enqueue(FUNC_PERIOD, 16'h0016, 1'b0, 8'h00, 1'b0);   // eight-bit, prefix kept
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h7E, 1'b1);
    enqueue(FUNC_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_PERIOD, 16'h8016, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h42, 1'b1);
    enqueue(FUNC_TXDATA, 16'h0100, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_PERIOD, 16'hFFFF, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_PERIOD, 16'hFFFF, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_PERIOD, 16'h7FFF, 1'b0, 8'h00, 1'b0);
    enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h01, 1'b1);
    enqueue(FUNC_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0);

    for (int phase = 1; phase <= 6; phase++) begin
      wait_drained();
      case (phase)
        1: begin ll = 1;   dm = 1; ot = 0;       end
        2: begin ll = 255; dm = 0; ot = 1048575; end
        3: begin ll = 0;   dm = 0; ot = 3;       end
        4: begin ll = 227; dm = 0; ot = 78125;   end
        5: begin
          ll = $urandom_range(1, 255);
          dm = $urandom_range(0, 1);
          ot = $urandom_range(0, 31);
        end
        default: begin
          ll = $urandom_range(1, 255);
          dm = 0;
          ot = $urandom_range(0, 10);
          idle_on = 1'b0;
        end
      endcase
      reg_write(REG_LINE_LENGTH, ll);
      reg_write(REG_DIRECT_MODE, dm);
      reg_write(REG_OVERRUN_TICKS, ot);
      if (phase == 1) begin
        // A second byte straight after a receive overruns when the limit is zero.
        enqueue(FUNC_PERIOD, 16'h0003, 1'b0, 8'h00, 1'b1);
        enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h11, 1'b1);
        enqueue(FUNC_TICK,   16'h0000, 1'b1, 8'h22, 1'b1);
        enqueue(FUNC_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0);
      end
      repeat (150) item_backlog.push_back(random_item());
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && owed_beats.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
